>>> rtl/core/tpjb_pkg.sv
// Shared types and constants for the timestamped packet jitter buffer.
// Sizing of the slot ring, stream word layout, command codes and sequencer states.
// No dependencies.
package tpjb_pkg;

  // Ring geometry
  localparam int BUFFER_DEPTH = 16;
  localparam int CHANNELS     = 2;
  localparam int FRAMES       = 16;
  localparam int SLOT_WORDS   = CHANNELS * FRAMES;
  localparam int RAM_DEPTH    = BUFFER_DEPTH * SLOT_WORDS;

  // Derived widths
  localparam int SLOT_W  = $clog2(BUFFER_DEPTH);
  localparam int WORD_W  = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
  localparam int ADDR_W  = $clog2(RAM_DEPTH);
  localparam int CNT_W   = $clog2(SLOT_WORDS + 1);
  localparam int STEP_W  = $clog2(BUFFER_DEPTH + 1);

  // Field widths
  localparam int CMD_W    = 2;
  localparam int TIME_W   = 63;
  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 5;
  localparam int POS_W    = 4;
  localparam int DIFF_W   = 64;
  localparam int TOL_W    = 32;

  // Stream word widths, padded to whole bytes
  localparam int IN_DATA_W  = ((TIME_W + SAMPLE_W + INDEX_W + 7) / 8) * 8;
  localparam int OUT_BITS   = SAMPLE_W + POS_W + DIFF_W + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [TOL_W-1:0] TOL_RESET = 32'd2666666;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_COMMIT = 2'd1,
    CMD_READ   = 2'd2,
    CMD_ALIGN  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_AL_DIFF,
    ST_AL_CHECK,
    ST_AL_OUT
  } state_t;

endpackage

>>> rtl/core/tpjb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Read data holds while the read enable is low. No dependencies.
module tpjb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/timestamped_packet_jitter_buffer.sv
// Top level of the timestamped packet jitter buffer: slot ring, sequencer, output register.
// Depends on tpjb_pkg and tpjb_ram.
//
// Throughput: sample writes and commits are taken in the idle state. A read fetches each word
// into the RAM read register, then moves it to the output register, one word per cycle while
// the sink is ready, bounded by the sample RAM's single registered read port. An align runs one
// walk step per pass through the shared subtract/compare unit, at most BUFFER_DEPTH steps.
// Reset (rst, synchronous, active high) starts a clearing pass over all RAM_DEPTH words (512 here)
// that zeroes the sample RAM; no word is accepted during it, configuration writes are.
module timestamped_packet_jitter_buffer
  import tpjb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Tolerance register write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [TOL_W-1:0]      cfg_data,
  // Command stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: time_value[62:0], sample_value[78:63], word_index[83:79], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: cmd[1:0]
  input  logic [CMD_W-1:0]      s_axis_tuser,
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: sample_out[15:0], read_position[19:16], time_diff[83:20], aligned[84], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  // Ring index helpers
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_W'(BUFFER_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] prev_slot(input logic [SLOT_W-1:0] s);
    prev_slot = (s == '0) ? SLOT_W'(BUFFER_DEPTH - 1) : s - 1'b1;
  endfunction

  state_t state, state_next;

  // Input word fields
  cmd_t                 in_cmd;
  logic [TIME_W-1:0]    in_time;
  logic [SAMPLE_W-1:0]  in_sample;
  logic [INDEX_W-1:0]   in_word;
  logic                 in_accept;
  logic                 word_ok;

  assign in_cmd    = cmd_t'(s_axis_tuser);
  assign in_time   = s_axis_tdata[TIME_W-1:0];
  assign in_sample = s_axis_tdata[TIME_W +: SAMPLE_W];
  assign in_word   = s_axis_tdata[TIME_W + SAMPLE_W +: INDEX_W];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  // Drop writes beyond the packet length
  assign word_ok   = 32'(in_word) < 32'(SLOT_WORDS);

  // Ring state
  logic [TOL_W-1:0]  tolerance;
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] read_slot;
  logic [TIME_W-1:0] slot_ts [BUFFER_DEPTH];

  // Clearing pass
  logic [ADDR_W-1:0] clr_addr;

  // Read burst
  logic [SLOT_W-1:0] rd_slot;
  logic [CNT_W-1:0]  iss_cnt;
  logic [CNT_W-1:0]  emit_cnt;
  logic              rd_pend;
  logic              rd_issue;
  logic              rd_load;

  // Align walk through the shared subtract/compare unit
  logic [TIME_W-1:0] al_time;
  logic [SLOT_W-1:0] al_stop;
  logic [STEP_W-1:0] al_steps;
  logic [DIFF_W-1:0] al_diff;
  logic [DIFF_W:0]   tol_sum;
  logic              in_tol;
  logic              step_go;
  logic              al_load;

  // Sample RAM ports
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  // Output register
  logic [SAMPLE_W-1:0]     o_sample;
  logic [POS_W-1:0]        o_pos;
  logic [DIFF_W-1:0]       o_diff;
  logic                    o_aligned;
  logic                    out_load;
  logic [SLOT_W+POS_W-1:0] pos_ext;
  logic [POS_W-1:0]        cur_pos;

  assign pos_ext = (SLOT_W + POS_W)'(read_slot);
  assign cur_pos = pos_ext[POS_W-1:0];

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);

  // Shared unit, compare half: |diff| <= tolerance. A negative diff is within range when
  // diff + tolerance does not go negative; a positive one compares directly.
  assign tol_sum = {al_diff[DIFF_W-1], al_diff} + (DIFF_W + 1)'(tolerance);
  assign in_tol  = al_diff[DIFF_W-1] ? !tol_sum[DIFF_W] : (al_diff <= DIFF_W'(tolerance));

  tpjb_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RAM_DEPTH)
  ) u_samples (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Datapath controls per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = ADDR_W'(rd_slot) * ADDR_W'(SLOT_WORDS) + ADDR_W'(iss_cnt[WORD_W-1:0]);
    rd_load   = 1'b0;
    rd_issue  = 1'b0;
    al_load   = 1'b0;
    step_go   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        ram_waddr = ADDR_W'(write_slot) * ADDR_W'(SLOT_WORDS) + ADDR_W'(in_word);
        ram_wdata = in_sample;
        ram_we    = in_accept && (in_cmd == CMD_WRITE) && word_ok;
      end
      ST_READ: begin
        // Move a fetched word into the output register when it is free, and keep
        // one fetch in flight behind it
        rd_load  = rd_pend && (!m_axis_tvalid || m_axis_tready);
        rd_issue = (iss_cnt < CNT_W'(SLOT_WORDS)) && (!rd_pend || rd_load);
        ram_re   = rd_issue;
      end
      ST_AL_CHECK: begin
        step_go = !in_tol && (read_slot != al_stop) && (al_steps < STEP_W'(BUFFER_DEPTH));
      end
      ST_AL_OUT: begin
        al_load = !m_axis_tvalid || m_axis_tready;
      end
      default: begin
      end
    endcase
  end

  assign out_load = rd_load || al_load;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(RAM_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (in_cmd)
            CMD_READ:  state_next = ST_READ;
            CMD_ALIGN: state_next = ST_AL_DIFF;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        if (rd_load && (emit_cnt == CNT_W'(SLOT_WORDS - 1))) begin
          state_next = ST_IDLE;
        end
      end
      ST_AL_DIFF: begin
        state_next = ST_AL_CHECK;
      end
      ST_AL_CHECK: begin
        state_next = step_go ? ST_AL_DIFF : ST_AL_OUT;
      end
      ST_AL_OUT: begin
        if (al_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      tolerance     <= TOL_RESET;
      write_slot    <= '0;
      read_slot     <= '0;
      rd_pend       <= 1'b0;
      iss_cnt       <= '0;
      emit_cnt      <= '0;
      al_steps      <= '0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
        slot_ts[i] <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        tolerance <= cfg_data;
      end

      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end

      if (in_accept) begin
        case (in_cmd)
          CMD_COMMIT: begin
            slot_ts[write_slot] <= in_time;
            write_slot          <= next_slot(write_slot);
          end
          CMD_READ: begin
            // Advance the read index up front; every word of the burst reports it
            read_slot <= next_slot(read_slot);
            iss_cnt   <= '0;
            emit_cnt  <= '0;
            rd_pend   <= 1'b0;
          end
          CMD_ALIGN: begin
            al_steps <= '0;
          end
          default: begin
          end
        endcase
      end

      if (rd_issue) begin
        iss_cnt <= iss_cnt + 1'b1;
      end
      if (rd_load) begin
        emit_cnt <= emit_cnt + 1'b1;
      end
      if (rd_issue) begin
        rd_pend <= 1'b1;
      end else if (rd_load) begin
        rd_pend <= 1'b0;
      end

      // Walk one slot toward the current time
      if (step_go) begin
        read_slot <= al_diff[DIFF_W-1] ? prev_slot(read_slot) : next_slot(read_slot);
        al_steps  <= al_steps + 1'b1;
      end

      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept && (in_cmd == CMD_READ)) begin
      rd_slot <= read_slot;
    end
    if (in_accept && (in_cmd == CMD_ALIGN)) begin
      al_time <= in_time;
      al_stop <= prev_slot(read_slot);
    end
    // Shared unit, subtract half: both times are below 2^63, so the difference is exact
    if (state == ST_AL_DIFF) begin
      al_diff <= {1'b0, al_time} - {1'b0, slot_ts[read_slot]};
    end
    if (rd_load) begin
      o_sample     <= ram_rdata;
      m_axis_tlast <= (emit_cnt == CNT_W'(SLOT_WORDS - 1));
      o_pos        <= cur_pos;
      o_diff       <= '0;
      o_aligned    <= 1'b0;
    end else if (al_load) begin
      o_sample     <= '0;
      m_axis_tlast <= 1'b1;
      o_pos        <= cur_pos;
      o_diff       <= al_diff;
      o_aligned    <= in_tol;
    end
  end

  assign m_axis_tdata = OUT_DATA_W'({o_aligned, o_diff, o_pos, o_sample});

  // A word can only be moved out after it was fetched
  a_fetch_before_load: assert property (@(posedge clk) disable iff (rst)
    rd_load |-> (emit_cnt < iss_cnt))
    else $error("read burst loads a word that was never fetched");

  // The walk never takes more than one lap of the ring
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    al_steps <= STEP_W'(BUFFER_DEPTH))
    else $error("align walk exceeded the ring depth");

  // A read command starts a fresh burst
  a_burst_start: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (in_cmd == CMD_READ)) |=>
      ((state == ST_READ) && (iss_cnt == '0) && (emit_cnt == '0) && !rd_pend))
    else $error("read burst did not start from an empty fetch state");

  // The output register is never overwritten while it holds an untaken word
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> !($past(rd_load) || $past(al_load)))
    else $error("output word overwritten before it was taken");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the timestamped packet jitter buffer: sample writes, commits,
// packet reads and time alignment, checked word by word against a built-in predictor.
// Depends on tpjb_pkg and the timestamped_packet_jitter_buffer RTL.
module tb_top;
  import tpjb_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 60;  // longer than the worst align walk
  localparam int PAD_IN_W      = IN_DATA_W - TIME_W - SAMPLE_W - INDEX_W;

  // One command word as the sender holds it
  typedef struct packed {
    cmd_t                  cmd;
    logic [TIME_W-1:0]     stamp;
    logic [SAMPLE_W-1:0]   sample;
    logic [INDEX_W-1:0]    word;
    logic                  drain;   // hold this word back until every result has come
  } command_word_t;

  // One result word as the block should emit it
  typedef struct packed {
    logic [SAMPLE_W-1:0]   sample;
    logic                  last;
    logic [POS_W-1:0]      position;
    logic [DIFF_W-1:0]     diff;
    logic                  aligned;
  } result_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [TOL_W-1:0]      cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  command_word_t pending_words[$];
  result_word_t  expected_words[$];
  command_word_t active_word;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int cycle_count    = 0;

  // Predictor copy of the ring
  logic [SAMPLE_W-1:0] model_samples [RAM_DEPTH];
  logic [DIFF_W-1:0]   model_stamps [BUFFER_DEPTH];
  logic [SLOT_W-1:0]   model_wr_slot;
  logic [SLOT_W-1:0]   model_rd_slot;
  logic [TOL_W-1:0]    model_tolerance;

  // Stimulus timeline: next packet timestamp and spacing between packets
  longint stream_clock;
  longint packet_period;

  always #5 clk = ~clk;

  timestamped_packet_jitter_buffer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic logic [DIFF_W-1:0] abs_offset(input logic [DIFF_W-1:0] d);
    return d[DIFF_W-1] ? -d : d;
  endfunction

  function automatic logic [TIME_W-1:0] random_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  function automatic void queue_word(input cmd_t cmd, input logic [TIME_W-1:0] stamp,
                                     input logic [SAMPLE_W-1:0] sample,
                                     input logic [INDEX_W-1:0] word, input logic drain);
    command_word_t w;
    w.cmd    = cmd;
    w.stamp  = stamp;
    w.sample = sample;
    w.word   = word;
    w.drain  = drain;
    pending_words.push_back(w);
  endfunction

  // Advance the predictor by one accepted command word and queue the result words it causes
  task automatic predict_buffer_output(input command_word_t w);
    logic [SLOT_W-1:0] start_slot;
    logic [SLOT_W-1:0] stop_slot;
    logic [DIFF_W-1:0] diff;
    int                steps;
    result_word_t      r;
    case (w.cmd)
      CMD_WRITE: begin
        model_samples[{model_wr_slot, w.word}] = w.sample;
      end
      CMD_COMMIT: begin
        model_stamps[model_wr_slot] = {1'b0, w.stamp};
        model_wr_slot = model_wr_slot + 1'b1;
      end
      CMD_READ: begin
        // No empty check: the read slot drains as it stands
        start_slot = model_rd_slot;
        model_rd_slot = model_rd_slot + 1'b1;
        for (int k = 0; k < SLOT_WORDS; k++) begin
          r.sample   = model_samples[{start_slot, k[WORD_W-1:0]}];
          r.last     = (k == SLOT_WORDS - 1);
          r.position = model_rd_slot;
          r.diff     = '0;
          r.aligned  = 1'b0;
          expected_words.push_back(r);
        end
      end
      CMD_ALIGN: begin
        // Walk toward the stamp; stop on the slot before the start or after a full lap
        stop_slot = model_rd_slot - 1'b1;
        steps = 0;
        diff = {1'b0, w.stamp} - model_stamps[model_rd_slot];
        while (abs_offset(diff) > model_tolerance && model_rd_slot != stop_slot &&
               steps < BUFFER_DEPTH) begin
          model_rd_slot = diff[DIFF_W-1] ? model_rd_slot - 1'b1 : model_rd_slot + 1'b1;
          steps++;
          diff = {1'b0, w.stamp} - model_stamps[model_rd_slot];
        end
        r.sample   = '0;
        r.last     = 1'b1;
        r.position = model_rd_slot;
        r.diff     = diff;
        r.aligned  = (abs_offset(diff) <= model_tolerance);
        expected_words.push_back(r);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Write the tolerance register; call only while the block is idle
  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    @(posedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    model_tolerance = value;
    cfg_valid <= 1'b0;
  endtask

  // Hold until the sender is empty and every result has come, then let the sequencer settle
  task automatic wait_until_idle();
    do begin
      @(posedge clk);
      while (pending_words.size() > 0 || s_axis_tvalid || expected_words.size() > 0)
        @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (pending_words.size() > 0 || s_axis_tvalid || expected_words.size() > 0);
  endtask

  // Mostly well-formed traffic: packet fills with commits, reads, and aligns near the
  // committed stamps; the rest is random words of any kind
  task automatic queue_random_traffic(input int count);
    int     queued;
    int     fill;
    int     pick;
    int     back;
    int     jitter;
    longint probe;
    queued = 0;
    while (queued < count) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        // Fill part of a packet, now and then all of it in order, then commit it
        fill = ($urandom_range(9) == 0) ? SLOT_WORDS : $urandom_range(1, 6);
        for (int k = 0; k < fill; k++)
          queue_word(CMD_WRITE, random_time(), SAMPLE_W'($urandom),
                     INDEX_W'((fill == SLOT_WORDS) ? k : $urandom_range(SLOT_WORDS - 1)),
                     1'b0);
        queue_word(CMD_COMMIT, TIME_W'(stream_clock), SAMPLE_W'($urandom),
                   INDEX_W'($urandom), 1'b0);
        stream_clock += packet_period;
        queued += fill + 1;
      end else if (pick < 62) begin
        queue_word(CMD_READ, random_time(), SAMPLE_W'($urandom), INDEX_W'($urandom),
                   ($urandom_range(19) == 0));
        queued++;
      end else if (pick < 85) begin
        // Current time a few packets back, with jitter around the tolerance
        back = $urandom_range(6);
        jitter = $urandom_range(3000000);
        jitter -= 1500000;
        if ($urandom_range(7) == 0)
          jitter = 0;
        probe = stream_clock - back * packet_period + jitter;
        queue_word(CMD_ALIGN, probe[TIME_W-1:0], SAMPLE_W'($urandom), INDEX_W'($urandom),
                   1'b0);
        queued++;
      end else if (pick < 93) begin
        queue_word(cmd_t'($urandom_range(3)), random_time(), SAMPLE_W'($urandom),
                   INDEX_W'($urandom), 1'b0);
        queued++;
      end else begin
        queue_word(CMD_ALIGN, random_time(), SAMPLE_W'($urandom), INDEX_W'($urandom), 1'b0);
        queued++;
      end
    end
  endtask

  // Sender: present one word at a time, predict on acceptance
  always @(posedge clk) begin : drive_commands
    logic          present;
    command_word_t w;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      present = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_buffer_output(active_word);
        present = 1'b0;
      end
      if (!present && pending_words.size() > 0 &&
          !(pending_words[0].drain && expected_words.size() > 0) &&
          $urandom_range(99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        active_word = w;
        s_axis_tdata <= {{PAD_IN_W{1'b0}}, w.word, w.sample, w.stamp};
        s_axis_tuser <= w.cmd;
        present = 1'b1;
      end
      s_axis_tvalid <= present;
    end
  end

  // Receiver: stall at random
  always @(posedge clk) begin
    m_axis_tready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : check_results
    result_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word: expected none, got %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("sample_out", 64'(want.sample), 64'(m_axis_tdata[SAMPLE_W-1:0]));
        check_field("last", 64'(want.last), 64'(m_axis_tlast));
        check_field("read_position", 64'(want.position),
                    64'(m_axis_tdata[SAMPLE_W +: POS_W]));
        check_field("time_diff", want.diff, m_axis_tdata[SAMPLE_W+POS_W +: DIFF_W]);
        check_field("aligned", 64'(want.aligned),
                    64'(m_axis_tdata[SAMPLE_W+POS_W+DIFF_W]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[timestamped_packet_jitter_buffer] ERROR");
      $finish;
    end
  end

  initial begin : run_test
    for (int i = 0; i < RAM_DEPTH; i++)
      model_samples[i] = '0;
    for (int i = 0; i < BUFFER_DEPTH; i++)
      model_stamps[i] = '0;
    model_wr_slot   = '0;
    model_rd_slot   = '0;
    model_tolerance = TOL_RESET;
    stream_clock    = longint'({$urandom, $urandom} >> 3);
    packet_period   = $urandom_range(1000000, 3000000);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset tolerance; the block takes them after its clearing pass
    queue_word(CMD_READ, '0, '0, '0, 1'b0);                    // never-written slot
    queue_word(CMD_WRITE, random_time(), 16'h8000, 5'd0, 1'b0);
    queue_word(CMD_WRITE, random_time(), 16'h7FFF, 5'd31, 1'b0);
    queue_word(CMD_WRITE, random_time(), 16'hFFFF, 5'd10, 1'b0);
    queue_word(CMD_WRITE, random_time(), 16'h0000, 5'd21, 1'b0);
    queue_word(CMD_COMMIT, '1, '0, '0, 1'b0);                  // largest stamp
    queue_word(CMD_WRITE, '0, 16'h5A5A, 5'd0, 1'b0);
    queue_word(CMD_COMMIT, '0, '0, '0, 1'b0);                  // zero stamp
    queue_word(CMD_ALIGN, '0, '0, '0, 1'b0);                   // already aligned
    queue_word(CMD_ALIGN, '1, '0, '0, 1'b0);                   // forward walk to the stop slot
    queue_word(CMD_ALIGN, '0, '0, '0, 1'b0);                   // backward step onto stop slot
    queue_word(CMD_READ, '0, '0, '0, 1'b1);                    // pause for every result first
    queue_word(CMD_READ, '1, '1, '1, 1'b0);
    queue_word(CMD_READ, '0, '0, '0, 1'b0);
    queue_word(CMD_ALIGN, 63'd5000000, '0, '0, 1'b0);          // oscillates until the step cap
    queue_word(CMD_COMMIT, 63'd5000000, '0, '0, 1'b0);
    queue_word(CMD_ALIGN, 63'd7666666, '0, '0, 1'b0);
    queue_word(CMD_ALIGN, 63'd2333334, '0, '0, 1'b0);
    wait_until_idle();

    // Random phases, each with its own tolerance and idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          write_tolerance('0);
        end
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 0;
          write_tolerance('1);
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 67;
          write_tolerance($urandom_range(3000000, 300000));
        end
        default: begin
          send_idle_pct  = 37;
          recv_stall_pct = 37;
          write_tolerance(TOL_RESET);
        end
      endcase
      packet_period = $urandom_range(1000000, 3000000);
      queue_random_traffic(48);
      wait_until_idle();
    end

    if (error_count == 0 && expected_words.size() == 0) begin
      $display("[timestamped_packet_jitter_buffer] OK");
    end else begin
      $display("[timestamped_packet_jitter_buffer] ERROR");
    end
    $finish;
  end

endmodule
